// File: hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds the request and result words, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ffha_pkg;

    localparam int REQ_SIZE_W = 13;
    localparam int ADDR_W     = 12;
    localparam int NEED_W     = 12;
    localparam int STATUS_W   = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_CO_ISSUE,
        ST_CO_FIRST,
        ST_CO_STEP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic                  req_type;
        logic [REQ_SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0]     req_addr;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   payload_addr;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ffha_engine.sv
// Header store and list-walking sequencer of the first-fit heap allocator.
// Holds the header memory and serves one allocate or free request at a time.
// Depends on ffha_pkg.
`default_nettype none

module ffha_engine #(
    parameter int HEAP_BYTES = 4096
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ffha_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ffha_pkg::res_t     res
);

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int PW    = $clog2(WORDS);
    localparam int LW    = $clog2(WORDS + 1);
    localparam int EW    = LW + 1;
    localparam int SW    = LW + 1;
    localparam int XW    = (SW > 14) ? SW : 14;
    localparam logic [XW-1:0] WORDS_X   = XW'(WORDS);
    localparam logic [EW-1:0] RESET_HDR = {LW'(WORDS), 1'b0};

    // Header memory: bit 0 is the allocated mark, the upper bits the block length in words.
    logic [EW-1:0] mem [WORDS];
    logic [EW-1:0] rdata_reg;
    logic [PW-1:0] raddr;
    logic          we;
    logic [PW-1:0] waddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Only word 0 is read before it is written, so it alone carries a valid flag.
    logic w0_valid_reg;
    logic rd0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_valid_reg <= 1'b0;
            rd0_reg      <= 1'b0;
        end else begin
            if (we && (waddr == '0)) begin
                w0_valid_reg <= 1'b1;
            end
            rd0_reg <= (raddr == '0);
        end
    end

    logic [EW-1:0] hdr;
    logic [LW-1:0] h_len;
    logic          h_alloc;

    assign hdr     = (rd0_reg && !w0_valid_reg) ? RESET_HDR : rdata_reg;
    assign h_len   = hdr[EW-1:1];
    assign h_alloc = hdr[0];

    ffha_pkg::state_t state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              type_reg, type_next;
    logic [ffha_pkg::NEED_W-1:0] need_reg, need_next;
    logic [XW-1:0]     tgt_reg, tgt_next;
    logic [PW-1:0]     cur_pos_reg, cur_pos_next;
    logic [LW-1:0]     cur_len_reg, cur_len_next;
    logic              cur_alloc_reg, cur_alloc_next;
    logic [PW-1:0]     sp_pos_reg, sp_pos_next;
    logic [LW-1:0]     sp_len_reg, sp_len_next;
    ffha_pkg::res_t    res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pos_reg       <= pos_next;
        type_reg      <= type_next;
        need_reg      <= need_next;
        tgt_reg       <= tgt_next;
        cur_pos_reg   <= cur_pos_next;
        cur_len_reg   <= cur_len_next;
        cur_alloc_reg <= cur_alloc_next;
        sp_pos_reg    <= sp_pos_next;
        sp_len_reg    <= sp_len_next;
        res_reg       <= res_next;
    end

    logic [13:0]   rsum;
    logic [11:0]   rwords;
    logic [XW-1:0] pos_x, len_x, next_x, need_x, pa_x;
    logic [XW-1:0] cpos_x, clen_x, cnext_x, nn_x;
    logic [LW-1:0] merged;

    assign rsum    = {1'b0, req.req_size} + 14'd3;
    assign rwords  = rsum[13:2];
    assign pos_x   = XW'(pos_reg);
    assign len_x   = XW'(h_len);
    assign next_x  = pos_x + len_x;
    assign need_x  = XW'(need_reg);
    assign pa_x    = (pos_x + XW'(1)) << 2;
    assign cpos_x  = XW'(cur_pos_reg);
    assign clen_x  = XW'(cur_len_reg);
    assign cnext_x = cpos_x + clen_x;
    assign merged  = cur_len_reg + h_len;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        type_next      = type_reg;
        need_next      = need_reg;
        tgt_next       = tgt_reg;
        cur_pos_next   = cur_pos_reg;
        cur_len_next   = cur_len_reg;
        cur_alloc_next = cur_alloc_reg;
        sp_pos_next    = sp_pos_reg;
        sp_len_next    = sp_len_reg;
        res_next       = res_reg;
        raddr          = '0;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = hdr;
        nn_x           = '0;
        req_ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ffha_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    type_next = req.req_type;
                    need_next = (rwords == '0) ? 12'd2 : rwords + 12'd1;
                    tgt_next  = XW'(req.req_addr[11:2]) - XW'(1);
                    pos_next  = '0;
                    if ((req.req_type == ffha_pkg::REQ_FREE)
                        && ((req.req_addr[11:2] == '0) || (req.req_addr[1:0] != 2'b00))) begin
                        res_next   = '{status: ffha_pkg::STATUS_BAD_FREE, payload_addr: '0};
                        state_next = ffha_pkg::ST_RESP;
                    end else begin
                        raddr      = '0;
                        state_next = ffha_pkg::ST_WALK;
                    end
                end
            end

            ffha_pkg::ST_WALK: begin
                if (type_reg == ffha_pkg::REQ_ALLOC) begin
                    if (h_len == '0) begin
                        res_next   = '{status: ffha_pkg::STATUS_NO_SPACE, payload_addr: '0};
                        state_next = ffha_pkg::ST_RESP;
                    end else if (!h_alloc && (len_x >= need_x)) begin
                        we       = 1'b1;
                        waddr    = pos_reg;
                        res_next = '{status: ffha_pkg::STATUS_OK, payload_addr: pa_x[11:0]};
                        if (len_x == need_x) begin
                            wdata      = {h_len, 1'b1};
                            state_next = ffha_pkg::ST_RESP;
                        end else begin
                            wdata       = {LW'(need_reg), 1'b1};
                            sp_pos_next = PW'(pos_x + need_x);
                            sp_len_next = h_len - LW'(need_reg);
                            state_next  = ffha_pkg::ST_SPLIT;
                        end
                    end else if (next_x >= WORDS_X) begin
                        res_next   = '{status: ffha_pkg::STATUS_NO_SPACE, payload_addr: '0};
                        state_next = ffha_pkg::ST_RESP;
                    end else begin
                        raddr    = next_x[PW-1:0];
                        pos_next = next_x[PW-1:0];
                    end
                end else begin
                    if (h_len == '0) begin
                        res_next   = '{status: ffha_pkg::STATUS_BAD_FREE, payload_addr: '0};
                        state_next = ffha_pkg::ST_RESP;
                    end else if (pos_x == tgt_reg) begin
                        if (h_alloc) begin
                            we         = 1'b1;
                            waddr      = pos_reg;
                            wdata      = {h_len, 1'b0};
                            state_next = ffha_pkg::ST_CO_ISSUE;
                        end else begin
                            res_next   = '{status: ffha_pkg::STATUS_BAD_FREE, payload_addr: '0};
                            state_next = ffha_pkg::ST_RESP;
                        end
                    end else if ((pos_x > tgt_reg) || (next_x >= WORDS_X)) begin
                        res_next   = '{status: ffha_pkg::STATUS_BAD_FREE, payload_addr: '0};
                        state_next = ffha_pkg::ST_RESP;
                    end else begin
                        raddr    = next_x[PW-1:0];
                        pos_next = next_x[PW-1:0];
                    end
                end
            end

            ffha_pkg::ST_SPLIT: begin
                we         = 1'b1;
                waddr      = sp_pos_reg;
                wdata      = {sp_len_reg, 1'b0};
                state_next = ffha_pkg::ST_RESP;
            end

            ffha_pkg::ST_CO_ISSUE: begin
                raddr      = '0;
                state_next = ffha_pkg::ST_CO_FIRST;
            end

            ffha_pkg::ST_CO_FIRST: begin
                cur_pos_next   = '0;
                cur_len_next   = h_len;
                cur_alloc_next = h_alloc;
                if ((h_len == '0) || (len_x >= WORDS_X)) begin
                    res_next   = '{status: ffha_pkg::STATUS_OK, payload_addr: '0};
                    state_next = ffha_pkg::ST_RESP;
                end else begin
                    raddr      = len_x[PW-1:0];
                    state_next = ffha_pkg::ST_CO_STEP;
                end
            end

            ffha_pkg::ST_CO_STEP: begin
                if (!cur_alloc_reg && !h_alloc && (h_len != '0)) begin
                    we           = 1'b1;
                    waddr        = cur_pos_reg;
                    wdata        = {merged, 1'b0};
                    cur_len_next = merged;
                    nn_x         = cpos_x + XW'(merged);
                end else begin
                    cur_pos_next   = cnext_x[PW-1:0];
                    cur_len_next   = h_len;
                    cur_alloc_next = h_alloc;
                    nn_x           = cnext_x + len_x;
                end
                if ((!(!cur_alloc_reg && !h_alloc) && (h_len == '0)) || (nn_x >= WORDS_X)
                    || (h_len == '0)) begin
                    res_next   = '{status: ffha_pkg::STATUS_OK, payload_addr: '0};
                    state_next = ffha_pkg::ST_RESP;
                end else begin
                    raddr = nn_x[PW-1:0];
                end
            end

            ffha_pkg::ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ffha_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ffha_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator: one request at a time, walking block headers one per cycle.
// An allocate walks the headers to the first fit and, when it splits a block, writes the
// header of the remainder; a free walks to its block, clears its mark and then merges adjacent
// free blocks in a pass from word 0. The next word can be taken in the same cycle that m_tvalid
// rises, even while the result waits. Reset leaves the heap one free block at once.
// Depends on ffha_pkg and ffha_engine.
`default_nettype none

module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // req_size[12:0], req_addr[24:13], zero fill above
    input  wire logic [0:0]  s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // payload_addr[11:0], zero fill above
    output logic [1:0]       m_tuser    // status[1:0]
);

    ffha_pkg::req_t req;
    ffha_pkg::res_t eng_res;
    logic           eng_res_valid;
    logic           eng_res_ready;

    assign req.req_type = s_tuser[0];
    assign req.req_size = s_tdata[12:0];
    assign req.req_addr = s_tdata[24:13];

    ffha_engine #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    logic           m_tvalid_reg, m_tvalid_next;
    ffha_pkg::res_t out_reg, out_next;

    assign eng_res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (eng_res_ready) begin
            m_tvalid_next = eng_res_valid;
            if (eng_res_valid) begin
                out_next = eng_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_reg.payload_addr};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire
